// ===== hw/rtl/tsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types and constants of the topic subscription fan-out table.
// ----------------------------------------------------------------------------
package tsf_pkg;

   localparam int TOPIC_SLOTS_DEF     = 16;
   localparam int MAX_SUBSCRIBERS_DEF = 8;

   localparam int MODE_W    = 3;
   localparam int ID_W      = 16;
   localparam int WORD_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int TSUBS_W   = 4;
   localparam int ACTIVE_W  = 5;
   localparam int REMOVED_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_SUBSCRIBE   = 3'd0,
      MODE_UNSUBSCRIBE = 3'd1,
      MODE_UNSUB_ALL   = 3'd2,
      MODE_PUBLISH     = 3'd3,
      MODE_QUERY       = 3'd4,
      MODE_CLEAR_TABLE = 3'd5,
      MODE_CLEAR_STATS = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_MEMORY = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_NO_SUBS   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOPIC_RD,
      ST_TOPIC_CMP,
      ST_TOPIC_DONE,
      ST_LIST_RD,
      ST_LIST_CMP,
      ST_LIST_DONE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_ALL_NEXT,
      ST_PUB_RD,
      ST_PUB_EMIT,
      ST_EMIT
   } state_type;

endpackage

// ===== hw/rtl/tsf_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface tsf_req_if;
   logic                          valid;
   logic                          ready;
   logic [tsf_pkg::MODE_W-1:0]    mode;
   logic [tsf_pkg::ID_W-1:0]      topic;
   logic [tsf_pkg::ID_W-1:0]      entity;
   logic [tsf_pkg::ID_W-1:0]      source_id;
   logic [tsf_pkg::WORD_W-1:0]    payload;

   modport source (output valid, mode, topic, entity, source_id, payload, input ready);
   modport sink   (input valid, mode, topic, entity, source_id, payload, output ready);
endinterface

// ===== hw/rtl/tsf_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_rsp_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface tsf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tsf_pkg::STATUS_W-1:0]    status;
   logic [tsf_pkg::ID_W-1:0]        destination;
   logic [tsf_pkg::ID_W-1:0]        out_source;
   logic [tsf_pkg::WORD_W-1:0]      out_payload;
   logic                            last;
   logic                            subscribed;
   logic [tsf_pkg::TSUBS_W-1:0]     topic_subscribers;
   logic [tsf_pkg::ACTIVE_W-1:0]    active_topics;
   logic [tsf_pkg::REMOVED_W-1:0]   removed_count;
   logic [tsf_pkg::WORD_W-1:0]      publish_total;
   logic [tsf_pkg::WORD_W-1:0]      no_subscriber_total;

   modport source (output valid, status, destination, out_source, out_payload, last,
                   subscribed, topic_subscribers, active_topics, removed_count,
                   publish_total, no_subscriber_total, input ready);
   modport sink   (input valid, status, destination, out_source, out_payload, last,
                   subscribed, topic_subscribers, active_topics, removed_count,
                   publish_total, no_subscriber_total, output ready);
endinterface

// ===== hw/rtl/topic_subscription_fanout_table_core.sv =====
`timescale 1ns / 1ps
// Topic search reads the used slots one by one, list search the list entries one by one,
// and closing a gap moves each later entry down by one; bookkeeping and the emit follow.
// Publish gives one copy per list RAM read, and waits while the result side stalls.
// Requests: one at a time, a new one is taken only in the idle state; unsubscribe all
// walks every used topic's list.
// Reset: clears the topic fill count, subscriber counts and both totals at once.
// ----------------------------------------------------------------------------
// topic_subscription_fanout_table_core
// Topic table with per-topic subscriber lists held in RAM; fans publishes out
// to every subscriber in list order.
// ----------------------------------------------------------------------------
module topic_subscription_fanout_table_core #(
   parameter int TOPIC_SLOTS     = tsf_pkg::TOPIC_SLOTS_DEF,
   parameter int MAX_SUBSCRIBERS = tsf_pkg::MAX_SUBSCRIBERS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   tsf_req_if.sink   req_ch,
   tsf_rsp_if.source rsp_ch
);

   localparam int TW    = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;
   localparam int UW    = $clog2(TOPIC_SLOTS + 1);
   localparam int CW    = $clog2(MAX_SUBSCRIBERS + 1);
   localparam int LDEP  = TOPIC_SLOTS * MAX_SUBSCRIBERS;
   localparam int LAW   = (LDEP > 1) ? $clog2(LDEP) : 1;
   localparam int ID_W  = tsf_pkg::ID_W;
   localparam int WD_W  = tsf_pkg::WORD_W;

   tsf_pkg::state_type  state_ff, state_in;
   tsf_pkg::mode_type   mode_ff, mode_in;
   tsf_pkg::status_type status_ff, status_in;

   logic [ID_W-1:0]  topic_ff, topic_in, entity_ff, entity_in, source_ff, source_in;
   logic [WD_W-1:0]  payload_ff, payload_in;
   logic [UW-1:0]    used_ff, used_in, tidx_ff, tidx_in, active_ff, active_in;
   logic [TW-1:0]    slot_ff, slot_in;
   logic [CW-1:0]    lidx_ff, lidx_in;
   logic [CW-1:0]    cnt_ff [TOPIC_SLOTS];
   logic [CW-1:0]    cnt_in [TOPIC_SLOTS];
   logic             found_ff, found_in, lfound_ff, lfound_in, subd_ff, subd_in;
   logic [tsf_pkg::REMOVED_W-1:0] removed_ff, removed_in;
   logic [WD_W-1:0]  pub_ctr_ff, pub_ctr_in, emp_ctr_ff, emp_ctr_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tsf_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]                   rsp_dest_ff, rsp_dest_in, rsp_src_ff, rsp_src_in;
   logic [WD_W-1:0]                   rsp_pay_ff, rsp_pay_in;
   logic                              rsp_last_ff, rsp_last_in, rsp_subd_ff, rsp_subd_in;
   logic [tsf_pkg::TSUBS_W-1:0]       rsp_tsubs_ff, rsp_tsubs_in;
   logic [tsf_pkg::ACTIVE_W-1:0]      rsp_active_ff, rsp_active_in;
   logic [tsf_pkg::REMOVED_W-1:0]     rsp_removed_ff, rsp_removed_in;
   logic [WD_W-1:0]                   rsp_pubtot_ff, rsp_pubtot_in;
   logic [WD_W-1:0]                   rsp_emptot_ff, rsp_emptot_in;

   logic             tram_we, tram_re;
   logic [TW-1:0]    tram_waddr, tram_raddr;
   logic [ID_W-1:0]  tram_wdata, tram_rdata;
   logic             lram_we, lram_re;
   logic [LAW-1:0]   lram_waddr, lram_raddr;
   logic [ID_W-1:0]  lram_wdata, lram_rdata;

   logic [CW-1:0]    cur_cnt;
   logic [LAW-1:0]   base_addr;
   logic [CW:0]      lidx_next;
   logic             out_free;
   logic             is_query;

   tsf_ram #(.WIDTH(ID_W), .DEPTH(TOPIC_SLOTS)) u_topic_ram (
      .clock   (clock),
      .wr_en   (tram_we),
      .wr_addr (tram_waddr),
      .wr_data (tram_wdata),
      .rd_en   (tram_re),
      .rd_addr (tram_raddr),
      .rd_data (tram_rdata)
   );

   tsf_ram #(.WIDTH(ID_W), .DEPTH(LDEP)) u_list_ram (
      .clock   (clock),
      .wr_en   (lram_we),
      .wr_addr (lram_waddr),
      .wr_data (lram_wdata),
      .rd_en   (lram_re),
      .rd_addr (lram_raddr),
      .rd_data (lram_rdata)
   );

   assign cur_cnt   = cnt_ff[slot_ff];
   assign base_addr = LAW'(slot_ff) * LAW'(MAX_SUBSCRIBERS);
   assign lidx_next = {1'b0, lidx_ff} + (CW+1)'(1);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign is_query  = (mode_ff == tsf_pkg::MODE_QUERY);

   assign req_ch.ready = (state_ff == tsf_pkg::ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      status_in  = status_ff;
      topic_in   = topic_ff;
      entity_in  = entity_ff;
      source_in  = source_ff;
      payload_in = payload_ff;
      used_in    = used_ff;
      tidx_in    = tidx_ff;
      active_in  = active_ff;
      slot_in    = slot_ff;
      lidx_in    = lidx_ff;
      cnt_in     = cnt_ff;
      found_in   = found_ff;
      lfound_in  = lfound_ff;
      subd_in    = subd_ff;
      removed_in = removed_ff;
      pub_ctr_in = pub_ctr_ff;
      emp_ctr_in = emp_ctr_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_dest_in    = rsp_dest_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_pay_in     = rsp_pay_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_subd_in    = rsp_subd_ff;
      rsp_tsubs_in   = rsp_tsubs_ff;
      rsp_active_in  = rsp_active_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_pubtot_in  = rsp_pubtot_ff;
      rsp_emptot_in  = rsp_emptot_ff;

      tram_we    = 1'b0;
      tram_waddr = used_ff[TW-1:0];
      tram_wdata = topic_ff;
      tram_re    = 1'b0;
      tram_raddr = tidx_ff[TW-1:0];
      lram_we    = 1'b0;
      lram_waddr = base_addr + LAW'(lidx_ff);
      lram_wdata = lram_rdata;
      lram_re    = 1'b0;
      lram_raddr = base_addr + LAW'(lidx_ff);

      unique case (state_ff)
         tsf_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in    = tsf_pkg::mode_type'(req_ch.mode);
               topic_in   = req_ch.topic;
               entity_in  = req_ch.entity;
               source_in  = req_ch.source_id;
               payload_in = req_ch.payload;
               status_in  = tsf_pkg::STATUS_OK;
               tidx_in    = '0;
               found_in   = 1'b0;
               subd_in    = 1'b0;
               removed_in = '0;
               case (tsf_pkg::mode_type'(req_ch.mode))
                  tsf_pkg::MODE_SUBSCRIBE, tsf_pkg::MODE_UNSUBSCRIBE,
                  tsf_pkg::MODE_QUERY: begin
                     state_in = tsf_pkg::ST_TOPIC_RD;
                  end
                  tsf_pkg::MODE_PUBLISH: begin
                     pub_ctr_in = pub_ctr_ff + WD_W'(1);
                     state_in   = tsf_pkg::ST_TOPIC_RD;
                  end
                  tsf_pkg::MODE_UNSUB_ALL: begin
                     state_in = tsf_pkg::ST_ALL_NEXT;
                  end
                  tsf_pkg::MODE_CLEAR_TABLE: begin
                     used_in   = '0;
                     active_in = '0;
                     for (int i = 0; i < TOPIC_SLOTS; i++) begin
                        cnt_in[i] = '0;
                     end
                     pub_ctr_in = '0;
                     emp_ctr_in = '0;
                     state_in   = tsf_pkg::ST_EMIT;
                  end
                  tsf_pkg::MODE_CLEAR_STATS: begin
                     pub_ctr_in = '0;
                     emp_ctr_in = '0;
                     state_in   = tsf_pkg::ST_EMIT;
                  end
                  default: begin
                     state_in = tsf_pkg::ST_EMIT;
                  end
               endcase
            end
         end

         tsf_pkg::ST_TOPIC_RD: begin
            if (tidx_ff == used_ff) begin
               found_in = 1'b0;
               state_in = tsf_pkg::ST_TOPIC_DONE;
            end else begin
               tram_re  = 1'b1;
               state_in = tsf_pkg::ST_TOPIC_CMP;
            end
         end

         tsf_pkg::ST_TOPIC_CMP: begin
            if (tram_rdata == topic_ff) begin
               found_in = 1'b1;
               slot_in  = tidx_ff[TW-1:0];
               state_in = tsf_pkg::ST_TOPIC_DONE;
            end else begin
               tidx_in  = tidx_ff + UW'(1);
               state_in = tsf_pkg::ST_TOPIC_RD;
            end
         end

         tsf_pkg::ST_TOPIC_DONE: begin
            lidx_in = '0;
            case (mode_ff)
               tsf_pkg::MODE_SUBSCRIBE: begin
                  if (found_ff) begin
                     state_in = tsf_pkg::ST_LIST_RD;
                  end else if (used_ff == UW'(TOPIC_SLOTS)) begin
                     status_in = tsf_pkg::STATUS_NO_MEMORY;
                     state_in  = tsf_pkg::ST_EMIT;
                  end else begin
                     // claim the next slot; its count is already zero
                     tram_we  = 1'b1;
                     used_in  = used_ff + UW'(1);
                     slot_in  = used_ff[TW-1:0];
                     state_in = tsf_pkg::ST_LIST_RD;
                  end
               end
               tsf_pkg::MODE_UNSUBSCRIBE: begin
                  if (found_ff) begin
                     state_in = tsf_pkg::ST_LIST_RD;
                  end else begin
                     status_in = tsf_pkg::STATUS_NOT_FOUND;
                     state_in  = tsf_pkg::ST_EMIT;
                  end
               end
               tsf_pkg::MODE_PUBLISH: begin
                  if (!found_ff || cur_cnt == '0) begin
                     emp_ctr_in = emp_ctr_ff + WD_W'(1);
                     status_in  = tsf_pkg::STATUS_NO_SUBS;
                     state_in   = tsf_pkg::ST_EMIT;
                  end else begin
                     state_in = tsf_pkg::ST_PUB_RD;
                  end
               end
               tsf_pkg::MODE_QUERY: begin
                  state_in = found_ff ? tsf_pkg::ST_LIST_RD : tsf_pkg::ST_EMIT;
               end
               default: begin
                  state_in = tsf_pkg::ST_EMIT;
               end
            endcase
         end

         tsf_pkg::ST_LIST_RD: begin
            if (lidx_ff == cur_cnt) begin
               lfound_in = 1'b0;
               state_in  = tsf_pkg::ST_LIST_DONE;
            end else begin
               lram_re  = 1'b1;
               state_in = tsf_pkg::ST_LIST_CMP;
            end
         end

         tsf_pkg::ST_LIST_CMP: begin
            if (lram_rdata == entity_ff) begin
               // lidx holds the position of the match
               lfound_in = 1'b1;
               state_in  = tsf_pkg::ST_LIST_DONE;
            end else begin
               lidx_in  = lidx_ff + CW'(1);
               state_in = tsf_pkg::ST_LIST_RD;
            end
         end

         tsf_pkg::ST_LIST_DONE: begin
            case (mode_ff)
               tsf_pkg::MODE_SUBSCRIBE: begin
                  state_in = tsf_pkg::ST_EMIT;
                  if (!lfound_ff) begin
                     if (cur_cnt == CW'(MAX_SUBSCRIBERS)) begin
                        status_in = tsf_pkg::STATUS_NO_MEMORY;
                     end else begin
                        lram_we         = 1'b1;
                        lram_waddr      = base_addr + LAW'(cur_cnt);
                        lram_wdata      = entity_ff;
                        cnt_in[slot_ff] = cur_cnt + CW'(1);
                        if (cur_cnt == '0) begin
                           active_in = active_ff + UW'(1);
                        end
                     end
                  end
               end
               tsf_pkg::MODE_UNSUBSCRIBE: begin
                  if (lfound_ff) begin
                     state_in = tsf_pkg::ST_SHIFT_RD;
                  end else begin
                     status_in = tsf_pkg::STATUS_NOT_FOUND;
                     state_in  = tsf_pkg::ST_EMIT;
                  end
               end
               tsf_pkg::MODE_UNSUB_ALL: begin
                  if (lfound_ff) begin
                     removed_in = removed_ff + tsf_pkg::REMOVED_W'(1);
                     state_in   = tsf_pkg::ST_SHIFT_RD;
                  end else begin
                     tidx_in  = tidx_ff + UW'(1);
                     state_in = tsf_pkg::ST_ALL_NEXT;
                  end
               end
               tsf_pkg::MODE_QUERY: begin
                  subd_in  = lfound_ff;
                  state_in = tsf_pkg::ST_EMIT;
               end
               default: begin
                  state_in = tsf_pkg::ST_EMIT;
               end
            endcase
         end

         tsf_pkg::ST_SHIFT_RD: begin
            if (lidx_next >= {1'b0, cur_cnt}) begin
               // gap closed: shorten the list
               cnt_in[slot_ff] = cur_cnt - CW'(1);
               if (cur_cnt == CW'(1)) begin
                  active_in = active_ff - UW'(1);
               end
               if (mode_ff == tsf_pkg::MODE_UNSUB_ALL) begin
                  tidx_in  = tidx_ff + UW'(1);
                  state_in = tsf_pkg::ST_ALL_NEXT;
               end else begin
                  state_in = tsf_pkg::ST_EMIT;
               end
            end else begin
               lram_re    = 1'b1;
               lram_raddr = base_addr + LAW'(lidx_next);
               state_in   = tsf_pkg::ST_SHIFT_WR;
            end
         end

         tsf_pkg::ST_SHIFT_WR: begin
            lram_we  = 1'b1;
            lidx_in  = lidx_ff + CW'(1);
            state_in = tsf_pkg::ST_SHIFT_RD;
         end

         tsf_pkg::ST_ALL_NEXT: begin
            if (tidx_ff == used_ff) begin
               state_in = tsf_pkg::ST_EMIT;
            end else begin
               slot_in  = tidx_ff[TW-1:0];
               lidx_in  = '0;
               state_in = tsf_pkg::ST_LIST_RD;
            end
         end

         tsf_pkg::ST_PUB_RD: begin
            lram_re  = 1'b1;
            state_in = tsf_pkg::ST_PUB_EMIT;
         end

         tsf_pkg::ST_PUB_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = tsf_pkg::STATUS_OK;
               rsp_dest_in    = lram_rdata;
               rsp_src_in     = source_ff;
               rsp_pay_in     = payload_ff;
               rsp_last_in    = (lidx_next == {1'b0, cur_cnt});
               rsp_subd_in    = 1'b0;
               rsp_tsubs_in   = '0;
               rsp_active_in  = '0;
               rsp_removed_in = '0;
               rsp_pubtot_in  = '0;
               rsp_emptot_in  = '0;
               if (lidx_next == {1'b0, cur_cnt}) begin
                  state_in = tsf_pkg::ST_IDLE;
               end else begin
                  lidx_in  = lidx_ff + CW'(1);
                  state_in = tsf_pkg::ST_PUB_RD;
               end
            end
         end

         tsf_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_dest_in    = '0;
               rsp_src_in     = '0;
               rsp_pay_in     = '0;
               rsp_last_in    = 1'b1;
               rsp_subd_in    = subd_ff;
               rsp_tsubs_in   = (is_query && found_ff) ? tsf_pkg::TSUBS_W'(cur_cnt) : '0;
               rsp_active_in  = is_query ? tsf_pkg::ACTIVE_W'(active_ff) : '0;
               rsp_removed_in = (mode_ff == tsf_pkg::MODE_UNSUB_ALL) ? removed_ff : '0;
               rsp_pubtot_in  = is_query ? pub_ctr_ff : '0;
               rsp_emptot_in  = is_query ? emp_ctr_ff : '0;
               state_in       = tsf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsf_pkg::ST_IDLE;
         used_ff      <= '0;
         active_ff    <= '0;
         pub_ctr_ff   <= '0;
         emp_ctr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TOPIC_SLOTS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         active_ff    <= active_in;
         pub_ctr_ff   <= pub_ctr_in;
         emp_ctr_ff   <= emp_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      status_ff      <= status_in;
      topic_ff       <= topic_in;
      entity_ff      <= entity_in;
      source_ff      <= source_in;
      payload_ff     <= payload_in;
      tidx_ff        <= tidx_in;
      slot_ff        <= slot_in;
      lidx_ff        <= lidx_in;
      found_ff       <= found_in;
      lfound_ff      <= lfound_in;
      subd_ff        <= subd_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_dest_ff    <= rsp_dest_in;
      rsp_src_ff     <= rsp_src_in;
      rsp_pay_ff     <= rsp_pay_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_subd_ff    <= rsp_subd_in;
      rsp_tsubs_ff   <= rsp_tsubs_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_pubtot_ff  <= rsp_pubtot_in;
      rsp_emptot_ff  <= rsp_emptot_in;
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.status              = rsp_status_ff;
   assign rsp_ch.destination         = rsp_dest_ff;
   assign rsp_ch.out_source          = rsp_src_ff;
   assign rsp_ch.out_payload         = rsp_pay_ff;
   assign rsp_ch.last                = rsp_last_ff;
   assign rsp_ch.subscribed          = rsp_subd_ff;
   assign rsp_ch.topic_subscribers   = rsp_tsubs_ff;
   assign rsp_ch.active_topics       = rsp_active_ff;
   assign rsp_ch.removed_count       = rsp_removed_ff;
   assign rsp_ch.publish_total       = rsp_pubtot_ff;
   assign rsp_ch.no_subscriber_total = rsp_emptot_ff;

endmodule

// ===== hw/rtl/tsf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/tb_topic_subscription_fanout_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_topic_subscription_fanout_table_core
// Drives subscribe, unsubscribe, publish, query and clear requests through the
// request channel and checks every result item against an internal table
// model. Both channels idle at random; the result side stalls once for long.
// ----------------------------------------------------------------------------
module tb_topic_subscription_fanout_table_core;
   import tsf_pkg::*;

   localparam int NT = TOPIC_SLOTS_DEF;
   localparam int NS = MAX_SUBSCRIBERS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   topic;
      logic [ID_W-1:0]   entity;
      logic [ID_W-1:0]   source;
      logic [WORD_W-1:0] payload;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ID_W-1:0]      destination;
      logic [ID_W-1:0]      out_source;
      logic [WORD_W-1:0]    out_payload;
      logic                 last;
      logic                 subscribed;
      logic [TSUBS_W-1:0]   topic_subscribers;
      logic [ACTIVE_W-1:0]  active_topics;
      logic [REMOVED_W-1:0] removed_count;
      logic [WORD_W-1:0]    publish_total;
      logic [WORD_W-1:0]    no_subscriber_total;
   } result_type;

   typedef struct {
      request_type req;
      bit          typed;
      result_type  res;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;

   tsf_req_if req_ch();
   tsf_rsp_if rsp_ch();

   topic_subscription_fanout_table_core DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // table model
   logic [ID_W-1:0]   topic_tab [NT];
   int                topic_cnt;
   logic [ID_W-1:0]   member_tab [NT][NS];
   int                member_cnt [NT];
   logic [WORD_W-1:0] publishes, empty_publishes;

   result_type expected_results [$];
   int      error_count = 0;
   int      accepted_results = 0;
   int      idle_cycles = 0;
   bit      stall_hold = 0;
   bit      no_idle = 0;
   int      publish_reqs = 0, fanout_results = 0;

   function automatic int lookup_slot(logic [ID_W-1:0] t);
      for (int i = 0; i < topic_cnt; i++) if (topic_tab[i] == t) return i;
      return -1;
   endfunction

   function automatic int find_member(int s, logic [ID_W-1:0] e);
      for (int i = 0; i < member_cnt[s]; i++) if (member_tab[s][i] == e) return i;
      return -1;
   endfunction

   function automatic void remove_member(int s, int p);
      for (int j = p; j + 1 < member_cnt[s]; j++) member_tab[s][j] = member_tab[s][j + 1];
      member_cnt[s]--;
   endfunction

   function automatic void clear_table();
      topic_cnt = 0;
      for (int i = 0; i < NT; i++) member_cnt[i] = 0;
      publishes = 0;
      empty_publishes = 0;
   endfunction

   // compute the result items of one request and advance the table
   function automatic void predict_fanout(request_type r);
      result_type o;
      int s, p, n;
      o = '0;
      o.last = 1;
      case (r.mode)
         MODE_SUBSCRIBE: begin
            s = lookup_slot(r.topic);
            if (s < 0 && topic_cnt >= NT) o.status = STATUS_NO_MEMORY;
            else begin
               if (s < 0) begin
                  s = topic_cnt;
                  topic_cnt++;
                  topic_tab[s] = r.topic;
                  member_cnt[s] = 0;
               end
               if (find_member(s, r.entity) < 0) begin
                  if (member_cnt[s] >= NS) o.status = STATUS_NO_MEMORY;
                  else begin
                     member_tab[s][member_cnt[s]] = r.entity;
                     member_cnt[s]++;
                  end
               end
            end
         end
         MODE_UNSUBSCRIBE: begin
            s = lookup_slot(r.topic);
            p = (s < 0) ? -1 : find_member(s, r.entity);
            if (p < 0) o.status = STATUS_NOT_FOUND;
            else remove_member(s, p);
         end
         MODE_UNSUB_ALL: begin
            n = 0;
            for (int i = 0; i < topic_cnt; i++) begin
               p = find_member(i, r.entity);
               if (p >= 0) begin
                  remove_member(i, p);
                  n++;
               end
            end
            o.removed_count = REMOVED_W'(n);
         end
         MODE_PUBLISH: begin
            publishes++;
            publish_reqs++;
            s = lookup_slot(r.topic);
            if (s < 0 || member_cnt[s] == 0) begin
               empty_publishes++;
               o.status = STATUS_NO_SUBS;
            end else begin
               for (int i = 0; i < member_cnt[s]; i++) begin
                  o.destination = member_tab[s][i];
                  o.out_source = r.source;
                  o.out_payload = r.payload;
                  o.last = (i + 1 == member_cnt[s]);
                  expected_results.push_back(o);
                  fanout_results++;
               end
               return;
            end
         end
         MODE_QUERY: begin
            s = lookup_slot(r.topic);
            if (s >= 0) begin
               o.subscribed = find_member(s, r.entity) >= 0;
               o.topic_subscribers = TSUBS_W'(member_cnt[s]);
            end
            n = 0;
            for (int i = 0; i < topic_cnt; i++) if (member_cnt[i] > 0) n++;
            o.active_topics = ACTIVE_W'(n);
            o.publish_total = publishes;
            o.no_subscriber_total = empty_publishes;
         end
         MODE_CLEAR_TABLE: clear_table();
         MODE_CLEAR_STATS: begin
            publishes = 0;
            empty_publishes = 0;
         end
         default: ;
      endcase
      expected_results.push_back(o);
   endfunction

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      error_count++;
      $display("MISMATCH result %0d %s: got %0h expected %0h",
               accepted_results, what, got, want);
   endtask

   // result checker and watchdog
   always @(posedge clock) begin
      result_type g, w;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            g = '{rsp_ch.status, rsp_ch.destination, rsp_ch.out_source, rsp_ch.out_payload,
                  rsp_ch.last, rsp_ch.subscribed, rsp_ch.topic_subscribers,
                  rsp_ch.active_topics, rsp_ch.removed_count, rsp_ch.publish_total,
                  rsp_ch.no_subscriber_total};
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item, destination", WORD_W'(g.destination), '0);
            end else begin
               w = expected_results.pop_front();
               if (g.status !== w.status)
                  report_mismatch("status", WORD_W'(g.status), WORD_W'(w.status));
               if (g.destination !== w.destination)
                  report_mismatch("destination", WORD_W'(g.destination),
                                  WORD_W'(w.destination));
               if (g.out_source !== w.out_source)
                  report_mismatch("out_source", WORD_W'(g.out_source),
                                  WORD_W'(w.out_source));
               if (g.out_payload !== w.out_payload)
                  report_mismatch("out_payload", g.out_payload, w.out_payload);
               if (g.last !== w.last)
                  report_mismatch("last", WORD_W'(g.last), WORD_W'(w.last));
               if (g.subscribed !== w.subscribed)
                  report_mismatch("subscribed", WORD_W'(g.subscribed), WORD_W'(w.subscribed));
               if (g.topic_subscribers !== w.topic_subscribers)
                  report_mismatch("topic_subscribers", WORD_W'(g.topic_subscribers),
                                  WORD_W'(w.topic_subscribers));
               if (g.active_topics !== w.active_topics)
                  report_mismatch("active_topics", WORD_W'(g.active_topics),
                                  WORD_W'(w.active_topics));
               if (g.removed_count !== w.removed_count)
                  report_mismatch("removed_count", WORD_W'(g.removed_count),
                                  WORD_W'(w.removed_count));
               if (g.publish_total !== w.publish_total)
                  report_mismatch("publish_total", g.publish_total, w.publish_total);
               if (g.no_subscriber_total !== w.no_subscriber_total)
                  report_mismatch("no_subscriber_total", g.no_subscriber_total,
                                  w.no_subscriber_total);
            end
            accepted_results <= accepted_results + 1;
         end
      end
   end

   // result side: random stalls, or a long hold when asked
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (stall_hold) rsp_ch.ready <= 0;
         else rsp_ch.ready <= no_idle || ($urandom_range(99) >= 28);
      end
   end

   task automatic send_request(request_type r);
      if (!no_idle)
         while ($urandom_range(99) < 28) begin
            req_ch.valid <= 0;
            @(negedge clock);
         end
      req_ch.valid <= 1;
      req_ch.mode <= r.mode;
      req_ch.topic <= r.topic;
      req_ch.entity <= r.entity;
      req_ch.source_id <= r.source;
      req_ch.payload <= r.payload;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_fanout(r);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   function automatic request_type rand_request(int mix);
      request_type r;
      int k;
      r.topic = (mix == 0) ? ID_W'($urandom_range(19)) : ID_W'($urandom);
      if (mix == 0 && $urandom_range(9) == 0) r.topic = ID_W'(16'hFFF0 + $urandom_range(15));
      r.entity = (mix == 0) ? ID_W'(16'h7FF8 + $urandom_range(15)) : ID_W'($urandom);
      r.source = ID_W'($urandom);
      r.payload = $urandom;
      k = $urandom_range(99);
      if (k < 35) r.mode = MODE_SUBSCRIBE;
      else if (k < 50) r.mode = MODE_UNSUBSCRIBE;
      else if (k < 56) r.mode = MODE_UNSUB_ALL;
      else if (k < 82) r.mode = MODE_PUBLISH;
      else if (k < 95) r.mode = MODE_QUERY;
      else if (k < 97) r.mode = MODE_CLEAR_TABLE;
      else if (k < 99) r.mode = MODE_CLEAR_STATS;
      else r.mode = 3'd7;
      return r;
   endfunction

   stim_row_type directed [$];

   function automatic void add_row(logic [MODE_W-1:0] m, logic [ID_W-1:0] t,
                                   logic [ID_W-1:0] e, bit typed, result_type res);
      stim_row_type row;
      row.req = '{m, t, e, 16'hFFFF, 32'hFFFF_FFFF};
      row.typed = typed;
      row.res = res;
      directed.push_back(row);
   endfunction

   initial begin
      result_type ok_last, nf, nosubs, q0, ra;
      request_type r;
      req_ch.valid = 0;
      req_ch.mode = '0;
      req_ch.topic = '0;
      req_ch.entity = '0;
      req_ch.source_id = '0;
      req_ch.payload = '0;
      ok_last = '0; ok_last.last = 1;
      nf = ok_last; nf.status = STATUS_NOT_FOUND;
      nosubs = ok_last; nosubs.status = STATUS_NO_SUBS;
      q0 = ok_last; q0.publish_total = 1; q0.no_subscriber_total = 1;
      ra = ok_last;

      clear_table();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: after reset, extremes, each status but no memory, and each mode
      add_row(MODE_PUBLISH, 16'hFFFF, 16'h0, 1, nosubs);
      add_row(MODE_QUERY, 16'hFFFF, 16'h0, 1, q0);
      add_row(MODE_UNSUBSCRIBE, 16'h0, 16'hFFFF, 1, nf);
      add_row(MODE_UNSUB_ALL, 16'h0, 16'hFFFF, 1, ra);
      add_row(MODE_SUBSCRIBE, 16'h0, 16'hFFFF, 1, ok_last);
      add_row(MODE_SUBSCRIBE, 16'h0, 16'hFFFF, 1, ok_last);
      add_row(MODE_SUBSCRIBE, 16'h0, 16'h0, 1, ok_last);
      add_row(MODE_SUBSCRIBE, 16'hFFFF, 16'hFFFF, 1, ok_last);
      add_row(MODE_PUBLISH, 16'h0, 16'h0, 0, ok_last);
      add_row(MODE_QUERY, 16'h0, 16'hFFFF, 0, ok_last);
      add_row(MODE_UNSUBSCRIBE, 16'h0, 16'hFFFF, 1, ok_last);
      add_row(MODE_UNSUBSCRIBE, 16'h0, 16'hFFFF, 1, nf);
      add_row(MODE_UNSUB_ALL, 16'h0, 16'h0, 0, ok_last);
      add_row(MODE_PUBLISH, 16'h0, 16'h0, 1, nosubs);
      add_row(MODE_QUERY, 16'h0, 16'h0, 0, ok_last);
      add_row(MODE_CLEAR_STATS, 16'h0, 16'h0, 1, ok_last);
      add_row(3'd7, 16'hFFFF, 16'hFFFF, 1, ok_last);
      add_row(MODE_QUERY, 16'hFFFF, 16'hFFFF, 0, ok_last);
      add_row(MODE_CLEAR_TABLE, 16'h0, 16'h0, 1, ok_last);
      add_row(MODE_QUERY, 16'hFFFF, 16'hFFFF, 1, ra);
      foreach (directed[i]) begin
         if (directed[i].typed) begin
            drain_results();
            send_request(directed[i].req);
            void'(expected_results.pop_back());
            expected_results.push_back(directed[i].res);
         end else
            send_request(directed[i].req);
      end
      drain_results();

      // fill a list past full, then the topic table past full
      for (int e = 0; e < NS + 2; e++)
         send_request('{MODE_SUBSCRIBE, 16'h5, ID_W'(e), '0, '0});
      send_request('{MODE_PUBLISH, 16'h5, '0, 16'hA5A5, 32'h1234_5678});
      for (int t = 0; t < NT + 2; t++)
         send_request('{MODE_SUBSCRIBE, ID_W'(16'h100 + t), 16'h9, '0, '0});
      send_request('{MODE_UNSUB_ALL, '0, 16'h9, '0, '0});
      send_request('{MODE_QUERY, 16'h5, 16'h3, '0, '0});
      send_request('{MODE_CLEAR_TABLE, '0, '0, '0, '0});

      // receiver holds off while requests keep coming
      fork
         begin
            stall_hold = 1;
            repeat (300) @(negedge clock);
            stall_hold = 0;
         end
         begin
            for (int e = 0; e < NS; e++)
               send_request('{MODE_SUBSCRIBE, 16'h33, ID_W'(16'h40 + e), '0, '0});
            repeat (6)
               send_request('{MODE_PUBLISH, 16'h33, '0, ID_W'($urandom), WORD_W'($urandom)});
         end
      join
      drain_results();

      for (int i = 0; i < 440; i++) begin
         no_idle = (i >= 200 && i < 260);
         r = rand_request(($urandom_range(9) == 0) ? 1 : 0);
         send_request(r);
      end
      no_idle = 0;
      drain_results();
      repeat (200) @(posedge clock);

      $display("Covered %0d publishes fanning out to %0d copies, %0d result items in all.",
               publish_reqs, fanout_results, accepted_results);
      if (error_count == 0 && expected_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
